// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/sbh_pkg.sv =====
// Shared types and constants of the sampled byte histogram.
package sbh_pkg;

	// Histogram geometry and field widths.
	localparam int NUM_BINS      = 256;
	localparam int BIN_W         = 8;
	localparam int PERIOD_W      = 16;
	localparam int OUT_COUNT_W   = 32;
	localparam int COUNT_W_DEF   = 32;

	// Operation codes carried by an input word.
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// Contents of the single processing stage.
	typedef struct packed {
		logic             vld;
		logic             rd;
		logic             smp;
		logic [BIN_W-1:0] addr;
	} stg_t;

endpackage

// ===== hw/rtl/sbh_if.sv =====
// Request and response channel interfaces of the histogram.
interface sbh_req_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [sbh_pkg::BIN_W-1:0]  byte_value;
	logic                       last_byte;
	logic [sbh_pkg::BIN_W-1:0]  bin_index;

	modport source (output valid, operation, byte_value, last_byte, bin_index, input ready);
	modport sink   (input valid, operation, byte_value, last_byte, bin_index, output ready);
endinterface

interface sbh_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [sbh_pkg::BIN_W-1:0]       bin_number;
	logic [sbh_pkg::OUT_COUNT_W-1:0] bin_count;

	modport source (output valid, bin_number, bin_count, input ready);
	modport sink   (input valid, bin_number, bin_count, output ready);
endinterface

// ===== hw/rtl/sbh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/sbh_sampler.sv =====
// Sample period register and in-packet position tracking.
module sbh_sampler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  logic                         last,
	input  logic                         wr_en,
	input  logic [sbh_pkg::PERIOD_W-1:0] wr_data,
	output logic                         smp
);
	import sbh_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] pos_q;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] pos_nxt;

	// A zero period behaves as one.
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign pos_nxt    = pos_q + PERIOD_W'(1);
	assign smp        = (pos_q == '0);

	// Period register and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(1);
			pos_q    <= '0;
		end else begin
			if (wr_en) begin
				period_q <= wr_data;
			end
			if (upd) begin
				if (last || (pos_nxt >= period_eff)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_nxt;
				end
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_last_restarts, clk, arst_n, upd && last, pos_q == '0)

endmodule

// ===== hw/rtl/sbh_update.sv =====
// Counter store with valid bits, write forwarding and increment.
module sbh_update #(
	parameter int COUNT_WIDTH = sbh_pkg::COUNT_W_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sbh_pkg::BIN_W-1:0] rd_addr,
	input  sbh_pkg::stg_t             stg,
	input  logic                      adv,
	output logic [COUNT_WIDTH-1:0]    cnt
);
	import sbh_pkg::*;

	logic                   vbits_q [NUM_BINS];
	logic                   fwd_vld_q;
	logic [BIN_W-1:0]       fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                   we;

	sbh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (stg.addr),
		.wdata (cnt_inc),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Current count: a write on the read edge wins, unwritten bins read zero.
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == stg.addr)) begin
			cnt = fwd_data_q;
		end else if (vbits_q[stg.addr]) begin
			cnt = rdata;
		end else begin
			cnt = '0;
		end
	end

	assign cnt_inc = cnt + COUNT_WIDTH'(1);
	assign we      = adv && stg.vld && !stg.rd && stg.smp;

	// Valid bits and the forwarding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				vbits_q[i] <= 1'b0;
			end
			fwd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vbits_q[stg.addr] <= 1'b1;
			end
			if (adv) begin
				fwd_vld_q <= we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= stg.addr;
			fwd_data_q <= cnt_inc;
		end
	end

endmodule

// ===== hw/rtl/sampled_byte_histogram_core.sv =====
// Sampled byte-value histogram: 256 counters, single-bin reads.
// A read word's result passes the processing stage register, then the output register.
// One word per cycle unless stalled, set by the RAM's one read and one write port.
// A read held behind an untaken response holds the processing stage and request ready.
// Reset clears all counters at once through per-bin valid bits; no clearing pass.
module sampled_byte_histogram_core #(
	parameter int COUNT_WIDTH = sbh_pkg::COUNT_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sbh_req_if.sink                      req,
	sbh_rsp_if.source                    rsp,
	input  logic                         wr_en,
	input  logic [sbh_pkg::PERIOD_W-1:0] wr_data
);
	import sbh_pkg::*;

	stg_t                   stg_s1;
	logic                   adv;
	logic                   acc;
	logic                   smp;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH+OUT_COUNT_W-1:0] cnt_ext;
	logic                   out_vld_q;
	logic [BIN_W-1:0]       out_bin_q;
	logic [OUT_COUNT_W-1:0] out_cnt_q;

	// Stage moves unless a read result is blocked by a full output register.
	assign adv       = !stg_s1.vld || !stg_s1.rd || !out_vld_q || rsp.ready;
	assign req.ready = adv;
	assign acc       = req.valid && adv;

	sbh_sampler u_sampler (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (acc && (req.operation == OP_BYTE)),
		.last    (req.last_byte),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.smp     (smp)
	);

	sbh_update #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr ((req.operation == OP_READ) ? req.bin_index : req.byte_value),
		.stg     (stg_s1),
		.adv     (adv),
		.cnt     (cnt)
	);

	// Processing stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1 <= '0;
		end else if (adv) begin
			stg_s1.vld  <= req.valid;
			stg_s1.rd   <= (req.operation == OP_READ);
			stg_s1.smp  <= smp;
			stg_s1.addr <= (req.operation == OP_READ) ? req.bin_index : req.byte_value;
		end
	end

	// Reported count is the low bits of the counter, zero-extended if narrower.
	assign cnt_ext = {{OUT_COUNT_W{1'b0}}, cnt};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && stg_s1.vld && stg_s1.rd) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stg_s1.vld && stg_s1.rd) begin
			out_bin_q <= stg_s1.addr;
			out_cnt_q <= cnt_ext[OUT_COUNT_W-1:0];
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.bin_number = out_bin_q;
	assign rsp.bin_count  = out_cnt_q;

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_stall_blocks_req, clk, arst_n, stg_s1.vld && stg_s1.rd && out_vld_q && !rsp.ready, !req.ready)
	`ASSERT_NEXT(a_read_gives_rsp, clk, arst_n, adv && stg_s1.vld && stg_s1.rd, out_vld_q)
	`ASSERT_NEXT(a_rsp_bin_match, clk, arst_n, adv && stg_s1.vld && stg_s1.rd, out_bin_q == $past(stg_s1.addr))

endmodule
